>>> rtl/core/wbpt_pkg.sv
`timescale 1ns / 1ps

package wbpt_pkg;

	localparam int unsigned MsPerSecond    = 1000;
	localparam int unsigned SecsPerMinute  = 60;
	localparam int unsigned LongBreakEvery = 4;

	// reciprocal of one second in ms, scaled by two to the RecipShift
	localparam int unsigned RecipShift = 26;
	localparam logic [16:0] RecipMul   = 17'd67109;

	localparam logic [7:0] WorkMinReset  = 8'd25;
	localparam logic [7:0] ShortMinReset = 8'd5;
	localparam logic [7:0] LongMinReset  = 8'd15;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_SKIP   = 3'd2,
		CMD_RESET  = 3'd3,
		CMD_SET    = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PH_WORK  = 2'd0,
		PH_SHORT = 2'd1,
		PH_LONG  = 2'd2
	} phase_t;

	localparam logic [1:0] PhSelInvalid = 2'd3;

	typedef enum logic [1:0] {
		REG_WORK_MIN  = 2'd0,
		REG_SHORT_MIN = 2'd1,
		REG_LONG_MIN  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] work_min;
		logic [7:0] short_min;
		logic [7:0] long_min;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [13:0] seconds;
		logic        run;
		logic [9:0]  accum;
		logic [15:0] sessions;
	} timer_state_t;

	function automatic logic [13:0] minutes_to_seconds(input logic [7:0] minutes);
		// m * 60 = m * 64 - m * 4
		return {minutes, 6'b0} - {4'b0, minutes, 2'b0};
	endfunction

	function automatic logic [13:0] phase_seconds(input logic [1:0] ph, input cfg_t cfg);
		logic [7:0] m;
		case (ph)
			PH_WORK:  m = cfg.work_min;
			PH_SHORT: m = cfg.short_min;
			default:  m = cfg.long_min;
		endcase
		return minutes_to_seconds(m);
	endfunction

endpackage

>>> rtl/core/work_break_phase_timer.sv
`timescale 1ns / 1ps
// a command beat accepted into the input register is resolved into the result register and offered from there
// throughput: one command per cycle, sustained while the result side takes beats
// the input register and the result register decouple the two sides
// reset (arst_n low, asynchronous): work phase, 1500 s left, stopped, no sessions,
// phase lengths back to 25 / 5 / 15 minutes, both stages empty
module work_break_phase_timer (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // elapsed_ms[15:0], phase_select[17:16], zero fill
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// phase[1:0], seconds_left[15:2], running[16], sessions_done[32:17],
	// alarm[33], alarm_kind[34], zero fill
	output logic [39:0] m_tdata,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// input stage
	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [15:0] elapsed_s1;
	logic [1:0]  sel_s1;

	// timer state and settings
	wbpt_pkg::timer_state_t state_q;
	wbpt_pkg::timer_state_t state_nxt;
	wbpt_pkg::cfg_t         cfg_q;

	// result stage
	logic        out_valid_q;
	logic [1:0]  phase_q;
	logic [13:0] seconds_q;
	logic        running_q;
	logic [15:0] sessions_q;
	logic        alarm_q;
	logic        kind_q;

	logic alarm_nxt;
	logic kind_nxt;
	logic advance;

	// the stage beat moves on when the result register is empty or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser;
			elapsed_s1 <= s_tdata[15:0];
			sel_s1     <= s_tdata[17:16];
		end
	end

	// register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work_min  <= wbpt_pkg::WorkMinReset;
			cfg_q.short_min <= wbpt_pkg::ShortMinReset;
			cfg_q.long_min  <= wbpt_pkg::LongMinReset;
		end else if (cfg_valid) begin
			case (wbpt_pkg::reg_idx_t'(cfg_index))
				wbpt_pkg::REG_WORK_MIN:  cfg_q.work_min  <= cfg_data;
				wbpt_pkg::REG_SHORT_MIN: cfg_q.short_min <= cfg_data;
				wbpt_pkg::REG_LONG_MIN:  cfg_q.long_min  <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole command is resolved between the input and the result register
	wbpt_step u_step (
		.cur          (state_q),
		.cfg          (cfg_q),
		.cmd          (cmd_s1),
		.elapsed_ms   (elapsed_s1),
		.phase_select (sel_s1),
		.nxt          (state_nxt),
		.alarm        (alarm_nxt),
		.alarm_kind   (kind_nxt)
	);

	// state is written as the beat leaves, so the next command sees it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= wbpt_pkg::PH_WORK;
			state_q.seconds  <= wbpt_pkg::minutes_to_seconds(wbpt_pkg::WorkMinReset);
			state_q.run      <= 1'b0;
			state_q.accum    <= '0;
			state_q.sessions <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			phase_q    <= state_nxt.phase;
			seconds_q  <= state_nxt.seconds;
			running_q  <= state_nxt.run;
			sessions_q <= state_nxt.sessions;
			alarm_q    <= alarm_nxt;
			kind_q     <= kind_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, kind_q, alarm_q, sessions_q, running_q, seconds_q, phase_q};

endmodule

>>> rtl/core/wbpt_step.sv
`timescale 1ns / 1ps

module wbpt_step (
	input  wbpt_pkg::timer_state_t cur,
	input  wbpt_pkg::cfg_t         cfg,
	input  logic [2:0]             cmd,
	input  logic [15:0]            elapsed_ms,
	input  logic [1:0]             phase_select,
	output wbpt_pkg::timer_state_t nxt,
	output logic                   alarm,
	output logic                   alarm_kind
);

	logic [16:0] sum;
	logic [33:0] prod;
	logic [6:0]  secs;
	logic [16:0] secs_ms;
	logic [16:0] rem;

	wbpt_pkg::timer_state_t fin;
	logic                   fin_kind;
	logic [15:0]            sess_inc;

	// ms to whole seconds: reciprocal multiply, exact for every reachable sum
	assign sum     = {7'b0, cur.accum} + {1'b0, elapsed_ms};
	assign prod    = sum * wbpt_pkg::RecipMul;
	assign secs    = prod[wbpt_pkg::RecipShift +: 7];
	assign secs_ms = {10'b0, secs} * 17'(wbpt_pkg::MsPerSecond);
	assign rem     = sum - secs_ms;

	assign sess_inc = cur.sessions + 16'd1;

	// phase completion
	always_comb begin
		fin          = cur;
		fin.run      = 1'b0;
		fin_kind     = 1'b0;
		if (cur.phase == wbpt_pkg::PH_WORK) begin
			fin.sessions = sess_inc;
			fin.phase    = (sess_inc[1:0] == 2'b00) ? wbpt_pkg::PH_LONG : wbpt_pkg::PH_SHORT;
		end else begin
			fin.phase = wbpt_pkg::PH_WORK;
			fin_kind  = 1'b1;
		end
		fin.seconds = wbpt_pkg::phase_seconds(fin.phase, cfg);
	end

	always_comb begin
		nxt        = cur;
		alarm      = 1'b0;
		alarm_kind = 1'b0;
		case (wbpt_pkg::cmd_t'(cmd))
			wbpt_pkg::CMD_TICK: begin
				if (!cur.run) begin
					nxt.accum = '0;
				end else if (sum >= 17'(wbpt_pkg::MsPerSecond)) begin
					if ({7'b0, secs} >= cur.seconds) begin
						nxt        = fin;
						nxt.accum  = rem[9:0];
						alarm      = 1'b1;
						alarm_kind = fin_kind;
					end else begin
						nxt.seconds = cur.seconds - {7'b0, secs};
						nxt.accum   = rem[9:0];
					end
				end else begin
					nxt.accum = sum[9:0];
				end
			end
			wbpt_pkg::CMD_TOGGLE: nxt.run = ~cur.run;
			wbpt_pkg::CMD_SKIP: begin
				nxt        = fin;
				alarm      = 1'b1;
				alarm_kind = fin_kind;
			end
			wbpt_pkg::CMD_RESET: begin
				nxt.run     = 1'b0;
				nxt.seconds = wbpt_pkg::phase_seconds(cur.phase, cfg);
			end
			wbpt_pkg::CMD_SET: begin
				if (phase_select != wbpt_pkg::PhSelInvalid) begin
					nxt.run     = 1'b0;
					nxt.phase   = phase_select;
					nxt.seconds = wbpt_pkg::phase_seconds(phase_select, cfg);
				end
			end
			default: nxt = cur;
		endcase
	end

endmodule

>>> rtl/core/wbpt_checker.sv
`timescale 1ns / 1ps

module wbpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled result beat stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// alarm kind only set with an alarm
	a_kind_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> m_tdata[33])
		else $error("alarm kind without alarm");

	// every alarm leaves the timer stopped
	a_alarm_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> !m_tdata[16])
		else $error("timer still running after alarm");

	// a finished work phase always moves to a break
	a_work_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] && !m_tdata[34] |-> m_tdata[1:0] != 2'd0)
		else $error("work phase end did not move to a break");

	// a finished break always returns to work
	a_break_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] && m_tdata[34] |-> m_tdata[1:0] == 2'd0)
		else $error("break end did not return to work");

endmodule

bind work_break_phase_timer wbpt_checker u_wbpt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> test/work_break_phase_timer_checker.sv
`timescale 1ns / 1ps
module work_break_phase_timer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int unsigned mismatches,
	output int unsigned pending
);

	typedef struct packed {
		wbpt_pkg::phase_t phase;
		logic [13:0]      seconds_left;
		logic             running;
		logic [15:0]      sessions_done;
		logic             alarm;
		logic             alarm_kind;
	} readout_t;

	// timer copy, phase lengths in minutes
	logic [7:0]       work_len;
	logic [7:0]       short_len;
	logic [7:0]       long_len;
	wbpt_pkg::phase_t cur_phase;
	logic [13:0]      secs_left;
	logic             counting;
	logic [9:0]       ms_carry;
	logic [15:0]      sessions;

	readout_t    readouts_due[$];
	int unsigned fault_cnt;

	function automatic logic [13:0] length_of(wbpt_pkg::phase_t ph);
		logic [7:0] minutes;
		case (ph)
			wbpt_pkg::PH_WORK:  minutes = work_len;
			wbpt_pkg::PH_SHORT: minutes = short_len;
			default:            minutes = long_len;
		endcase
		return 14'(minutes) * 14'(wbpt_pkg::SecsPerMinute);
	endfunction

	// ends the current phase and moves on, gives the alarm kind
	function automatic logic close_phase();
		counting = 1'b0;
		if (cur_phase == wbpt_pkg::PH_WORK) begin
			sessions  = sessions + 16'd1;
			cur_phase = (sessions % wbpt_pkg::LongBreakEvery == 0) ?
				wbpt_pkg::PH_LONG : wbpt_pkg::PH_SHORT;
			secs_left = length_of(cur_phase);
			return 1'b0;
		end
		cur_phase = wbpt_pkg::PH_WORK;
		secs_left = length_of(wbpt_pkg::PH_WORK);
		return 1'b1;
	endfunction

	task automatic advance_timer(input wbpt_pkg::cmd_t cmd, input logic [15:0] ms,
			input logic [1:0] sel, output readout_t r);
		logic [16:0] total;
		logic [6:0]  whole;
		r.alarm      = 1'b0;
		r.alarm_kind = 1'b0;
		case (cmd)
			wbpt_pkg::CMD_TICK: begin
				if (!counting) begin
					ms_carry = '0;
				end else begin
					total = 17'(ms_carry) + 17'(ms);
					if (total >= 17'(wbpt_pkg::MsPerSecond)) begin
						whole    = 7'(total / wbpt_pkg::MsPerSecond);
						ms_carry = 10'(total % wbpt_pkg::MsPerSecond);
						if (14'(whole) >= secs_left) begin
							secs_left    = '0;
							r.alarm_kind = close_phase();
							r.alarm      = 1'b1;
						end else begin
							secs_left = secs_left - 14'(whole);
						end
					end else begin
						ms_carry = 10'(total);
					end
				end
			end
			wbpt_pkg::CMD_TOGGLE: counting = !counting;
			wbpt_pkg::CMD_SKIP: begin
				r.alarm_kind = close_phase();
				r.alarm      = 1'b1;
			end
			wbpt_pkg::CMD_RESET: begin
				counting  = 1'b0;
				secs_left = length_of(cur_phase);
			end
			wbpt_pkg::CMD_SET: begin
				if (sel != wbpt_pkg::PhSelInvalid) begin
					counting  = 1'b0;
					cur_phase = wbpt_pkg::phase_t'(sel);
					secs_left = length_of(cur_phase);
				end
			end
			default: ;
		endcase
		r.phase         = cur_phase;
		r.seconds_left  = secs_left;
		r.running       = counting;
		r.sessions_done = sessions;
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			fault_cnt++;
			if (fault_cnt <= 10)
				$display("%0t: %0s mismatch, expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		readout_t want;
		readout_t fresh;
		if (!arst_n) begin
			work_len  = wbpt_pkg::WorkMinReset;
			short_len = wbpt_pkg::ShortMinReset;
			long_len  = wbpt_pkg::LongMinReset;
			cur_phase = wbpt_pkg::PH_WORK;
			secs_left = length_of(wbpt_pkg::PH_WORK);
			counting  = 1'b0;
			ms_carry  = '0;
			sessions  = '0;
			readouts_due.delete();
			fault_cnt = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (wbpt_pkg::reg_idx_t'(cfg_index))
					wbpt_pkg::REG_WORK_MIN:  work_len  = cfg_data;
					wbpt_pkg::REG_SHORT_MIN: short_len = cfg_data;
					wbpt_pkg::REG_LONG_MIN:  long_len  = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (readouts_due.size() == 0) begin
					fault_cnt++;
					if (fault_cnt <= 10)
						$display("%0t: result beat with nothing pending, data %h", $realtime, m_tdata);
				end else begin
					want = readouts_due.pop_front();
					check_field("phase", want.phase, m_tdata[1:0]);
					check_field("seconds_left", want.seconds_left, m_tdata[15:2]);
					check_field("running", want.running, m_tdata[16]);
					check_field("sessions_done", want.sessions_done, m_tdata[32:17]);
					check_field("alarm", want.alarm, m_tdata[33]);
					check_field("alarm_kind", want.alarm_kind, m_tdata[34]);
				end
			end
			if (s_tvalid && s_tready) begin
				advance_timer(wbpt_pkg::cmd_t'(s_tuser), s_tdata[15:0], s_tdata[17:16], fresh);
				readouts_due.push_back(fresh);
			end
			mismatches <= fault_cnt;
			pending    <= readouts_due.size();
		end
	end

endmodule

>>> test/tb_work_break_phase_timer.sv
`timescale 1ns / 1ps
module tb_work_break_phase_timer;

	// cycles without any accepted beat before the run is declared hung
	localparam int unsigned IdleLimit    = 2000;
	// margin after the last result
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned RandomPerSet = 215;
	// command codes the block does not decode
	localparam logic [2:0]  CmdSpareLo   = 3'd5;
	localparam logic [2:0]  CmdSpareHi   = 3'd7;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [2:0]  s_tuser   = wbpt_pkg::CMD_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data  = '0;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned idle_cycles = 0;
	// commands left in a run of back-to-back beats
	int unsigned burst_left  = 0;
	// cycles the result side keeps its current ready level
	int unsigned hold_left   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	work_break_phase_timer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	work_break_phase_timer_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// result side back-pressure: long ready stretches, mostly short stalls, a few long ones
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ($urandom_range(0, 2) != 0) begin
			m_tready  <= 1'b1;
			hold_left <= $urandom_range(0, 40);
		end else begin
			m_tready  <= 1'b0;
			hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
		end
	end

	// watchdog on accepted beats of any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IdleLimit) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// idle cycles before the next command beat
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one command beat; tvalid stays high afterwards unless a gap follows
	task automatic send_command(input logic [2:0] cmd, input logic [15:0] ms, input logic [1:0] sel);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {6'b0, sel, ms};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random_command();
		logic [2:0]  cmd;
		logic [15:0] ms;
		logic [1:0]  sel;
		int unsigned roll;
		// mostly ticks so that phases actually run out
		roll = $urandom_range(0, 99);
		if (roll < 58)
			cmd = wbpt_pkg::CMD_TICK;
		else if (roll < 70)
			cmd = wbpt_pkg::CMD_TOGGLE;
		else if (roll < 78)
			cmd = wbpt_pkg::CMD_SKIP;
		else if (roll < 84)
			cmd = wbpt_pkg::CMD_RESET;
		else if (roll < 94)
			cmd = wbpt_pkg::CMD_SET;
		else
			cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
		// sub-second steps exercise the ms carry, big ones burn through the phase
		case ($urandom_range(0, 9))
			0:       ms = 16'($urandom_range(0, 999));
			1:       ms = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			2, 3:    ms = 16'($urandom());
			default: ms = 16'($urandom_range(5000, 65535));
		endcase
		sel = ($urandom_range(0, 7) == 0) ? wbpt_pkg::PhSelInvalid : 2'($urandom_range(0, 2));
		send_command(cmd, ms, sel);
	endtask

	// stop sending and wait for every pending result beat
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// writes all three phase lengths, only called while the block is idle
	task automatic program_lengths(input logic [7:0] work_min, input logic [7:0] short_min,
			input logic [7:0] long_min);
		logic [7:0] lengths [3];
		lengths[wbpt_pkg::REG_WORK_MIN]  = work_min;
		lengths[wbpt_pkg::REG_SHORT_MIN] = short_min;
		lengths[wbpt_pkg::REG_LONG_MIN]  = long_min;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= wbpt_pkg::reg_idx_t'(i);
			cfg_data  <= lengths[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset lengths
		send_command(wbpt_pkg::CMD_TICK, 16'hFFFF, wbpt_pkg::PH_WORK);   // paused tick clears
		send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK); // start
		send_command(wbpt_pkg::CMD_TICK, 16'd999, wbpt_pkg::PH_WORK);    // just short of a second
		send_command(wbpt_pkg::CMD_TICK, 16'd1, wbpt_pkg::PH_WORK);      // carry rolls over
		send_command(wbpt_pkg::CMD_TICK, 16'hFFFF, wbpt_pkg::PH_LONG);   // 65 s plus remainder
		send_command(wbpt_pkg::CMD_TICK, 16'h0000, wbpt_pkg::PH_WORK);
		send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK); // pause keeps the carry
		send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK);
		send_command(wbpt_pkg::CMD_TICK, 16'd465, wbpt_pkg::PH_WORK);    // kept carry completes
		send_command(wbpt_pkg::CMD_RESET, 16'h0000, wbpt_pkg::PH_WORK);
		// skips through four work sessions, the fourth leads to a long break
		repeat (7) send_command(wbpt_pkg::CMD_SKIP, 16'h0000, wbpt_pkg::PH_WORK);
		send_command(wbpt_pkg::CMD_SET, 16'h0000, wbpt_pkg::PhSelInvalid);  // ignored
		send_command(wbpt_pkg::CMD_SET, 16'h0000, wbpt_pkg::PH_SHORT);
		send_command(wbpt_pkg::CMD_SET, 16'h0000, wbpt_pkg::PH_LONG);
		send_command(wbpt_pkg::CMD_SET, 16'h0000, wbpt_pkg::PH_WORK);
		for (int c = CmdSpareLo; c <= CmdSpareHi; c++)
			send_command(3'(c), 16'hFFFF, wbpt_pkg::PhSelInvalid);
		send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK);
		// skip while running stops the timer
		send_command(wbpt_pkg::CMD_SKIP, 16'h0000, wbpt_pkg::PH_WORK);
		drain();

		// random part over several length settings, extremes among them
		for (int set_no = 0; set_no < 7; set_no++) begin
			case (set_no)
				0:       program_lengths(8'd0, 8'd0, 8'd0);
				1:       program_lengths(8'd1, 8'd1, 8'd2);
				2:       program_lengths(8'd255, 8'd255, 8'd255);
				3:       program_lengths(8'd2, 8'd0, 8'd255);
				4:       program_lengths(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
						8'($urandom_range(0, 3)));
				5:       program_lengths(8'($urandom()), 8'($urandom()), 8'($urandom()));
				default: program_lengths(wbpt_pkg::WorkMinReset, wbpt_pkg::ShortMinReset,
						wbpt_pkg::LongMinReset);
			endcase
			if (set_no == 0) begin
				// zero-length phase: completes only on the first tick giving a whole second
				send_command(wbpt_pkg::CMD_SET, 16'h0000, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TICK, 16'd999, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TICK, 16'd1, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TOGGLE, 16'h0000, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TICK, 16'h0000, wbpt_pkg::PH_WORK);
				send_command(wbpt_pkg::CMD_TICK, 16'd1000, wbpt_pkg::PH_WORK);
			end
			repeat (RandomPerSet) send_random_command();
			drain();
		end

		repeat (SettleCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/wbpt_pkg.sv
rtl/core/wbpt_step.sv
rtl/core/work_break_phase_timer.sv
rtl/core/wbpt_checker.sv
test/work_break_phase_timer_checker.sv
test/tb_work_break_phase_timer.sv
